// ===== rtl/core/edrle_pkg.sv =====
// ----------------------------------------------------------------------------
// edrle_pkg: shared types and constants of the escape run-length decoder
// Holds the queue entry format passed from the front end to the back end,
// the escape byte and the fixed load addresses.
// ----------------------------------------------------------------------------
package edrle_pkg;

  // Escape marker of the compressed form.
  localparam logic [7:0] ESC_BYTE = 8'hED;

  // Block length that marks an uncompressed 16 KiB page.
  localparam logic [15:0] RAW_BLOCK_MARK = 16'hFFFF;
  localparam logic [15:0] RAW_BLOCK_LEN = 16'h4000;

  // Load addresses.
  localparam logic [15:0] ADDR_START = 16'h4000;
  localparam logic [15:0] ADDR_PAGE4 = 16'h8000;
  localparam logic [15:0] ADDR_PAGE5 = 16'hC000;
  localparam logic [15:0] ADDR_PAGE8 = 16'h4000;
  localparam logic [15:0] ADDR_OTHER = 16'h0000;

  // Page numbers with a fixed mapping.
  localparam logic [7:0] PAGE_4 = 8'd4;
  localparam logic [7:0] PAGE_5 = 8'd5;
  localparam logic [7:0] PAGE_8 = 8'd8;

  // Format mode codes.
  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_PACKED = 2'd1;
  localparam logic [1:0] MODE_BLOCKS = 2'd2;

  // Queue between front end and back end.
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // One decoded input byte: one run, optionally followed by a single
  // literal byte at the next address.
  typedef struct packed {
    logic        two_runs;
    logic [15:0] addr0;
    logic [7:0]  byte0;
    logic [7:0]  len0;
    logic [7:0]  byte1;
  } run_entry_t;

endpackage

// ===== rtl/core/edrle_front.sv =====
// ----------------------------------------------------------------------------
// edrle_front: byte classifier and decode state
// Accepts one byte per cycle while q_full is low, walks block headers and
// escape sequences, tracks the write address and queues the resulting runs.
// ----------------------------------------------------------------------------
module edrle_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 cfg_valid,
  input  logic [1:0]           format_mode,
  input  logic                 q_full,
  output logic                 q_push,
  output edrle_pkg::run_entry_t q_entry
);
  import edrle_pkg::*;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_ESC1   = 3'd2;
  localparam logic [2:0] PH_ESC2   = 3'd3;
  localparam logic [2:0] PH_ESC3   = 3'd4;
  localparam logic [2:0] PH_LEN_HI = 3'd5;
  localparam logic [2:0] PH_PAGE   = 3'd6;

  logic [1:0]  mode;
  logic [2:0]  phase, phase_next;
  logic [15:0] left, left_next;
  logic        comp, comp_next;
  logic [15:0] addr, addr_next;
  logic [7:0]  held, held_next;
  logic        accept;
  logic        blocks;
  logic        body;
  logic [2:0]  body_phase;
  logic [1:0]  n_runs;
  logic [15:0] hdr_len;

  assign accept = push && !q_full;
  assign blocks = mode >= MODE_BLOCKS;
  assign hdr_len = {data_byte, held};

  // Header walk, escape decoding and block byte count.
  always_comb begin
    phase_next = phase;
    left_next = left;
    comp_next = comp;
    addr_next = addr;
    held_next = held;
    body = 1'b0;
    body_phase = phase;
    n_runs = 2'd0;
    q_entry = '0;
    q_entry.addr0 = addr;

    // Header bytes and stream start.
    if (phase inside {PH_DATA, PH_ESC1, PH_ESC2, PH_ESC3}) begin
      body = 1'b1;
    end else if (phase == PH_LEN_HI) begin
      if (hdr_len == RAW_BLOCK_MARK) begin
        left_next = RAW_BLOCK_LEN;
        comp_next = 1'b0;
      end else begin
        left_next = hdr_len;
        comp_next = 1'b1;
      end
      phase_next = PH_PAGE;
    end else if (phase == PH_PAGE) begin
      case (data_byte)
        PAGE_4:  addr_next = ADDR_PAGE4;
        PAGE_5:  addr_next = ADDR_PAGE5;
        PAGE_8:  addr_next = ADDR_PAGE8;
        default: addr_next = ADDR_OTHER;
      endcase
      phase_next = (left != 16'd0) ? PH_DATA : PH_START;
    end else begin
      if (blocks) begin
        held_next = data_byte;
        phase_next = PH_LEN_HI;
      end else begin
        comp_next = (mode == MODE_PACKED);
        body_phase = PH_DATA;
        body = 1'b1;
      end
    end

    // Body byte decoding.
    if (body) begin
      case (body_phase)
        PH_ESC1: begin
          if (data_byte != ESC_BYTE) begin
            n_runs = 2'd2;
            q_entry.two_runs = 1'b1;
            q_entry.byte0 = ESC_BYTE;
            q_entry.len0 = 8'd1;
            q_entry.byte1 = data_byte;
            addr_next = addr + 16'd2;
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_ESC2;
          end
        end
        PH_ESC2: begin
          held_next = data_byte;
          phase_next = PH_ESC3;
        end
        PH_ESC3: begin
          // A zero count writes nothing.
          if (held != 8'd0) begin
            n_runs = 2'd1;
            q_entry.byte0 = data_byte;
            q_entry.len0 = held;
            addr_next = addr + {8'd0, held};
          end
          phase_next = PH_DATA;
        end
        default: begin
          if (comp_next && data_byte == ESC_BYTE) begin
            phase_next = PH_ESC1;
          end else begin
            n_runs = 2'd1;
            q_entry.byte0 = data_byte;
            q_entry.len0 = 8'd1;
            addr_next = addr + 16'd1;
            phase_next = PH_DATA;
          end
        end
      endcase
      // A block that runs out drops any unfinished escape.
      if (blocks) begin
        if (left != 16'd0) begin
          left_next = left - 16'd1;
        end
        if (left_next == 16'd0) begin
          phase_next = PH_START;
        end
      end
    end

    // The final byte of a snapshot returns to the start state.
    if (last_byte) begin
      phase_next = PH_START;
      left_next = 16'd0;
      comp_next = 1'b0;
      addr_next = ADDR_START;
      held_next = 8'd0;
    end
  end

  assign q_push = accept && (n_runs != 2'd0);

  // Mode register; the write channel is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BLOCKS;
    end else if (cfg_valid) begin
      mode <= format_mode;
    end
  end

  // Decode state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      left <= 16'd0;
      comp <= 1'b0;
      addr <= ADDR_START;
      held <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      left <= left_next;
      comp <= comp_next;
      addr <= addr_next;
      held <= held_next;
    end
  end

endmodule

// ===== rtl/core/edrle_queue.sv =====
// ----------------------------------------------------------------------------
// edrle_queue: short run queue
// A small register queue that decouples the byte decoder from the run
// output, so each side can stall on its own.
// ----------------------------------------------------------------------------
module edrle_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_push,
  input  edrle_pkg::run_entry_t q_wdata,
  input  logic                  q_pop,
  output edrle_pkg::run_entry_t q_rdata,
  output logic                  q_full,
  output logic                  q_empty
);
  import edrle_pkg::*;

  run_entry_t      slots [QDEPTH];
  logic [QAW-1:0]  wptr;
  logic [QAW-1:0]  rptr;
  logic [QAW:0]    count;
  logic            do_push;
  logic            do_pop;

  assign q_full = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_push = q_push && !q_full;
  assign do_pop = q_pop && !q_empty;
  assign q_rdata = slots[rptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= q_wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/edrle_back.sv =====
// ----------------------------------------------------------------------------
// edrle_back: run output stage
// Takes queue entries, splits double entries into two runs and holds the
// oldest run in an output register until it is popped.
// ----------------------------------------------------------------------------
module edrle_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  edrle_pkg::run_entry_t q_rdata,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [15:0]           run_address,
  output logic [7:0]            run_byte,
  output logic [7:0]            run_length,
  output logic                  last_of_item
);
  import edrle_pkg::*;

  logic        out_valid;
  logic        pend_valid;
  logic [15:0] pend_addr;
  logic [7:0]  pend_byte;
  logic        advance;

  assign empty = !out_valid;
  assign advance = !out_valid || pop;
  assign q_pop = advance && !pend_valid && !q_empty;

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (advance) begin
      if (pend_valid) begin
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        pend_valid <= q_rdata.two_runs;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run payload; the second literal of a pair follows the first.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend_valid) begin
        run_address <= pend_addr;
        run_byte <= pend_byte;
        run_length <= 8'd1;
        last_of_item <= 1'b1;
      end else if (!q_empty) begin
        run_address <= q_rdata.addr0;
        run_byte <= q_rdata.byte0;
        run_length <= q_rdata.len0;
        last_of_item <= !q_rdata.two_runs;
        pend_addr <= q_rdata.addr0 + 16'd1;
        pend_byte <= q_rdata.byte1;
      end
    end
  end

endmodule

// ===== rtl/core/ed_escape_rle_snapshot_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ed_escape_rle_snapshot_decoder_top: ED-escape run-length memory decoder
// Decodes snapshot memory data, raw, compressed or in paged blocks, into
// runs of memory writes.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while full is low and answers
// with runs of address, byte and length, oldest first. Most bytes give at
// most one run and flow through at one per cycle unless the queue is full;
// an escape followed by a non-escape byte gives two runs, which leave the
// output register one after the other. A four-entry queue between the byte
// decoder and the output register absorbs these bursts and any stall on the
// result side, so full rises only when the queue holds four undelivered
// entries. A run is written into a queue slot when its byte is accepted and
// moves from there into the output register once that register is free.
// The format register is always ready and should be written only while the
// block is idle.
module ed_escape_rle_snapshot_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  format_mode,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] run_address,
  output logic [7:0]  run_byte,
  output logic [7:0]  run_length,
  output logic        last_of_item
);
  import edrle_pkg::*;

  run_entry_t q_wdata;
  run_entry_t q_rdata;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  assign cfg_ready = 1'b1;
  assign full = q_full;

  // Byte decoder.
  edrle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .format_mode (format_mode),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_wdata)
  );

  // Run queue.
  edrle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Output stage.
  edrle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .run_address  (run_address),
    .run_byte     (run_byte),
    .run_length   (run_length),
    .last_of_item (last_of_item)
  );

  // A shown run always writes at least one byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> run_length != 8'd0)
    else $error("run with zero length on result ports");

  // The first run of a pair is followed at once by the second.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_item) |=> !empty && last_of_item)
    else $error("second run of a literal pair missing");

  // The second run of a pair sits at the next address.
  a_pair_addr: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_item) |=>
      run_address == 16'($past(run_address) + 16'd1))
    else $error("second run of a pair at wrong address");

endmodule
